// ----- design/html_text_extractor_macros.svh -----
// assertion macros for the html text extractor
// expects clk and arst_n in the scope of every use
`ifndef HTML_TEXT_EXTRACTOR_MACROS_SVH
`define HTML_TEXT_EXTRACTOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HTE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("html_text_extractor: same-cycle check failed");
// next-cycle implication
`define HTE_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("html_text_extractor: next-cycle check failed");
`else
`define HTE_ASSERT_IMP(label, ante, cons)
`define HTE_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- design/hte_pkg.sv -----
// shared types, constants and lookup tables of the html text extractor
// used by the channel interfaces and the top level
package hte_pkg;

	localparam int DATA_W = 8;
	localparam int CHAR_W = 7;
	localparam int LEN_W = 16;
	localparam int ENTITY_NAME_MAX_DEF = 9;
	localparam logic [LEN_W-1:0] LIMIT_RESET = 16'hFFFF;

	localparam logic [DATA_W-1:0] CH_LT = "<";
	localparam logic [DATA_W-1:0] CH_GT = ">";
	localparam logic [DATA_W-1:0] CH_AMP = "&";
	localparam logic [DATA_W-1:0] CH_SEMI = ";";
	localparam logic [DATA_W-1:0] CH_S = "s";
	localparam logic [DATA_W-1:0] CH_C = "c";
	localparam logic [DATA_W-1:0] CH_T = "t";

	localparam int OPEN_SCRIPT_LEN = 7;
	localparam int OPEN_STYLE_LEN = 6;
	localparam int CLOSE_SCRIPT_LEN = 9;
	localparam int CLOSE_STYLE_LEN = 8;
	localparam logic [8*OPEN_SCRIPT_LEN-1:0] OPEN_SCRIPT = "<script";
	localparam logic [8*OPEN_STYLE_LEN-1:0] OPEN_STYLE = "<style";
	localparam logic [8*CLOSE_SCRIPT_LEN-1:0] CLOSE_SCRIPT = "</script>";
	localparam logic [8*CLOSE_STYLE_LEN-1:0] CLOSE_STYLE = "</style>";

	// entity table: names up to six characters, left aligned
	localparam int ENT_ROWS = 16;
	localparam int ENT_NAME_LEN = 6;

	typedef enum logic [6:0] {
		M_TEXT        = 7'b0000001,
		M_TAG         = 7'b0000010,
		M_TAG_SCRIPT  = 7'b0000100,
		M_TAG_STYLE   = 7'b0001000,
		M_SKIP_SCRIPT = 7'b0010000,
		M_SKIP_STYLE  = 7'b0100000,
		M_ENTITY      = 7'b1000000
	} mode_t;

	typedef struct packed {
		logic [8*ENT_NAME_LEN-1:0] name;
		logic [2:0]                len;
		logic [CHAR_W-1:0]         repl;
	} ent_row_t;

	// out of range positions give zero, which never matches a nonzero word
	function automatic logic [DATA_W-1:0] open_script_char(input logic [2:0] i);
		if (int'(i) < OPEN_SCRIPT_LEN)
			return OPEN_SCRIPT[8*(OPEN_SCRIPT_LEN-1-int'(i)) +: 8];
		return '0;
	endfunction

	function automatic logic [DATA_W-1:0] open_style_char(input logic [2:0] i);
		if (int'(i) < OPEN_STYLE_LEN)
			return OPEN_STYLE[8*(OPEN_STYLE_LEN-1-int'(i)) +: 8];
		return '0;
	endfunction

	function automatic logic [DATA_W-1:0] close_script_char(input logic [3:0] i);
		if (int'(i) < CLOSE_SCRIPT_LEN)
			return CLOSE_SCRIPT[8*(CLOSE_SCRIPT_LEN-1-int'(i)) +: 8];
		return '0;
	endfunction

	function automatic logic [DATA_W-1:0] close_style_char(input logic [3:0] i);
		if (int'(i) < CLOSE_STYLE_LEN)
			return CLOSE_STYLE[8*(CLOSE_STYLE_LEN-1-int'(i)) +: 8];
		return '0;
	endfunction

	function automatic logic is_name_char(input logic [DATA_W-1:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
			(b >= "0" && b <= "9") || b == "#";
	endfunction

	function automatic ent_row_t ent_row(input logic [3:0] r);
		ent_row_t row;
		case (r)
			4'd0:  row = '{{"lt", 32'd0}, 3'd2, 7'h3C};
			4'd1:  row = '{{"gt", 32'd0}, 3'd2, 7'h3E};
			4'd2:  row = '{{"amp", 24'd0}, 3'd3, 7'h26};
			4'd3:  row = '{{"quot", 16'd0}, 3'd4, 7'h22};
			4'd4:  row = '{{"#39", 24'd0}, 3'd3, 7'h27};
			4'd5:  row = '{{"apos", 16'd0}, 3'd4, 7'h27};
			4'd6:  row = '{{"nbsp", 16'd0}, 3'd4, 7'h20};
			4'd7:  row = '{"middot", 3'd6, 7'h2D};
			4'd8:  row = '{{"bull", 16'd0}, 3'd4, 7'h2D};
			4'd9:  row = '{{"ndash", 8'd0}, 3'd5, 7'h2D};
			4'd10: row = '{{"mdash", 8'd0}, 3'd5, 7'h2D};
			4'd11: row = '{{"lsquo", 8'd0}, 3'd5, 7'h27};
			4'd12: row = '{{"rsquo", 8'd0}, 3'd5, 7'h27};
			4'd13: row = '{{"ldquo", 8'd0}, 3'd5, 7'h22};
			4'd14: row = '{{"rdquo", 8'd0}, 3'd5, 7'h22};
			default: row = '{"hellip", 3'd6, 7'h2E};
		endcase
		return row;
	endfunction

endpackage

// ----- design/hte_if.sv -----
// valid/ready channels of the html text extractor: document words in, text words out
// depends on hte_pkg for field widths
interface hte_in_if;
	logic                           valid;
	logic                           ready;
	logic [hte_pkg::DATA_W-1:0]     doc_byte;

	modport source (output valid, output doc_byte, input ready);
	modport sink (input valid, input doc_byte, output ready);
endinterface

interface hte_out_if;
	logic                           valid;
	logic                           ready;
	logic [hte_pkg::CHAR_W-1:0]     text_byte;
	logic                           char_valid;
	logic                           end_of_text;
	logic [hte_pkg::LEN_W-1:0]      text_length;

	modport source (output valid, output text_byte, output char_valid,
		output end_of_text, output text_length, input ready);
	modport sink (input valid, input text_byte, input char_valid,
		input end_of_text, input text_length, output ready);
endinterface

// ----- design/html_text_extractor.sv -----
// html text extractor top level: tag stripping, script/style skipping, entity decode
// depends on hte_pkg, hte_if.sv and html_text_extractor_macros.svh
//
//   channel    dir  handshake     word
//   doc_in     in   valid/ready   doc_byte
//   text_out   out  valid/ready   text_byte, char_valid, end_of_text, text_length
//   cfg        in   cfg_we        cfg_wdata (output limit)
//
// one document word is taken per cycle while doc_in is ready; its parser update is
// done in the accept cycle; results go to a burst register that shifts out one word
// per cycle while text_out is ready; a word that makes several results holds doc_in
// until its last result leaves (entity flush: up to ENTITY_NAME_MAX+2 results);
// single results flow back to back; arst_n clears parser state and the burst, and
// the output limit resets to 65535; text_out stalls hold the burst; doc_in is ready
// when the burst is empty or its last word leaves in the same cycle
`include "html_text_extractor_macros.svh"

module html_text_extractor #(
	parameter int ENTITY_NAME_MAX = hte_pkg::ENTITY_NAME_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [hte_pkg::LEN_W-1:0]  cfg_wdata,
	hte_in_if.sink                     doc_in,
	hte_out_if.source                  text_out
);

	localparam int CNT_W = $clog2(ENTITY_NAME_MAX + 1);
	localparam int IDX_W = $clog2(ENTITY_NAME_MAX);
	localparam int SLOTS = ENTITY_NAME_MAX + 2;
	localparam int SLOT_W = $clog2(SLOTS + 1);
	localparam int LEN_W = hte_pkg::LEN_W;
	localparam int CHAR_W = hte_pkg::CHAR_W;

	// parser state
	logic [LEN_W-1:0]   limit_q;
	hte_pkg::mode_t     mode_q, mode_d;
	logic [2:0]         otp_q, otp_d;
	logic [3:0]         ctp_q, ctp_d;
	logic [CHAR_W-1:0]  ebuf_q [ENTITY_NAME_MAX];
	logic [CNT_W-1:0]   ecnt_q, ecnt_d;
	logic [LEN_W-1:0]   emitted_q, emitted_d;
	logic               reached_q, reached_d;

	// result burst
	logic [CHAR_W-1:0]  slot_q [SLOTS];
	logic [CHAR_W-1:0]  slot_d [SLOTS];
	logic [SLOT_W-1:0]  left_q;
	logic               end_q;
	logic [LEN_W-1:0]   base_q;

	logic [hte_pkg::DATA_W-1:0] din;
	logic               accept, pop, one_left;
	logic [LEN_W-1:0]   cap, avail;
	logic               wr_en, fl, trail, text_path;
	logic [CHAR_W-1:0]  tch;
	logic [SLOT_W-1:0]  base_idx, req, n_emit;
	logic               ent_hit;
	logic [CHAR_W-1:0]  ent_ch;

	assign din = doc_in.doc_byte;
	assign accept = doc_in.valid && doc_in.ready;
	assign pop = text_out.valid && text_out.ready;

	// limit 0 acts as 1
	assign cap = (limit_q == '0) ? '0 : limit_q - LEN_W'(1);
	assign avail = (reached_q || (emitted_q >= cap)) ? '0 : cap - emitted_q;

	// entity name lookup against the 16-entry table
	always_comb begin
		hte_pkg::ent_row_t row;
		logic row_ok;
		ent_hit = 1'b0;
		ent_ch = '0;
		for (int r = 0; r < hte_pkg::ENT_ROWS; r++) begin
			row = hte_pkg::ent_row(4'(r));
			row_ok = (ecnt_q == CNT_W'(row.len));
			for (int i = 0; i < hte_pkg::ENT_NAME_LEN; i++) begin
				if (3'(i) < row.len &&
						ebuf_q[i] != row.name[8*(hte_pkg::ENT_NAME_LEN-1-i) +: CHAR_W])
					row_ok = 1'b0;
			end
			if (row_ok && !ent_hit) begin
				ent_hit = 1'b1;
				ent_ch = row.repl;
			end
		end
	end

	// parser next state for the word at the input
	always_comb begin
		mode_d = mode_q;
		otp_d = otp_q;
		ctp_d = ctp_q;
		ecnt_d = ecnt_q;
		reached_d = reached_q;
		wr_en = 1'b0;
		fl = 1'b0;
		trail = 1'b0;
		tch = '0;
		text_path = 1'b0;
		if (din == '0) begin
			// end of document: flush a pending entity, then back to reset
			fl = (mode_q == hte_pkg::M_ENTITY);
			mode_d = hte_pkg::M_TEXT;
			otp_d = '0;
			ctp_d = '0;
			ecnt_d = '0;
			reached_d = 1'b0;
		end else if (avail == '0) begin
			reached_d = 1'b1;
		end else begin
			unique case (mode_q)
				hte_pkg::M_TAG: begin
					if (din == hte_pkg::CH_GT) begin
						mode_d = hte_pkg::M_TEXT;
						otp_d = '0;
					end else if (otp_q == 3'd1 && din == hte_pkg::CH_S) begin
						otp_d = 3'd2;
					end else if (otp_q == 3'd2 && din == hte_pkg::CH_C) begin
						mode_d = hte_pkg::M_TAG_SCRIPT;
						otp_d = 3'd3;
					end else if (otp_q == 3'd2 && din == hte_pkg::CH_T) begin
						mode_d = hte_pkg::M_TAG_STYLE;
						otp_d = 3'd3;
					end else begin
						otp_d = '0;
					end
				end
				hte_pkg::M_TAG_SCRIPT: begin
					if (din == hte_pkg::CH_GT) begin
						mode_d = hte_pkg::M_TEXT;
						otp_d = '0;
					end else if (din == hte_pkg::open_script_char(otp_q)) begin
						if (int'(otp_q) == hte_pkg::OPEN_SCRIPT_LEN - 1) begin
							mode_d = hte_pkg::M_SKIP_SCRIPT;
							ctp_d = '0;
							otp_d = '0;
						end else begin
							otp_d = otp_q + 3'd1;
						end
					end else begin
						mode_d = hte_pkg::M_TAG;
						otp_d = '0;
					end
				end
				hte_pkg::M_TAG_STYLE: begin
					if (din == hte_pkg::CH_GT) begin
						mode_d = hte_pkg::M_TEXT;
						otp_d = '0;
					end else if (din == hte_pkg::open_style_char(otp_q)) begin
						if (int'(otp_q) == hte_pkg::OPEN_STYLE_LEN - 1) begin
							mode_d = hte_pkg::M_SKIP_STYLE;
							ctp_d = '0;
							otp_d = '0;
						end else begin
							otp_d = otp_q + 3'd1;
						end
					end else begin
						mode_d = hte_pkg::M_TAG;
						otp_d = '0;
					end
				end
				hte_pkg::M_SKIP_SCRIPT: begin
					if (din == hte_pkg::close_script_char(ctp_q)) begin
						if (int'(ctp_q) == hte_pkg::CLOSE_SCRIPT_LEN - 1) begin
							mode_d = hte_pkg::M_TEXT;
							ctp_d = '0;
						end else begin
							ctp_d = ctp_q + 4'd1;
						end
					end else begin
						ctp_d = (din == hte_pkg::CH_LT) ? 4'd1 : 4'd0;
					end
				end
				hte_pkg::M_SKIP_STYLE: begin
					if (din == hte_pkg::close_style_char(ctp_q)) begin
						if (int'(ctp_q) == hte_pkg::CLOSE_STYLE_LEN - 1) begin
							mode_d = hte_pkg::M_TEXT;
							ctp_d = '0;
						end else begin
							ctp_d = ctp_q + 4'd1;
						end
					end else begin
						ctp_d = (din == hte_pkg::CH_LT) ? 4'd1 : 4'd0;
					end
				end
				hte_pkg::M_ENTITY: begin
					if (hte_pkg::is_name_char(din) && int'(ecnt_q) < ENTITY_NAME_MAX) begin
						wr_en = 1'b1;
						ecnt_d = ecnt_q + CNT_W'(1);
					end else if (din == hte_pkg::CH_SEMI) begin
						mode_d = hte_pkg::M_TEXT;
						ecnt_d = '0;
						trail = ent_hit;
						tch = ent_ch;
					end else begin
						// failed entity: write it out as is, then treat the word as text if room is left
						fl = 1'b1;
						mode_d = hte_pkg::M_TEXT;
						ecnt_d = '0;
						if (LEN_W'(ecnt_q) + LEN_W'(1) < avail)
							text_path = 1'b1;
						else
							reached_d = 1'b1;
					end
				end
				default: begin
					mode_d = hte_pkg::M_TEXT;
					text_path = 1'b1;
				end
			endcase
			if (text_path) begin
				if (din == hte_pkg::CH_LT) begin
					mode_d = hte_pkg::M_TAG;
					otp_d = 3'd1;
				end else if (din == hte_pkg::CH_AMP) begin
					mode_d = hte_pkg::M_ENTITY;
					ecnt_d = '0;
				end else if (!din[7]) begin
					trail = 1'b1;
					tch = din[CHAR_W-1:0];
				end
			end
		end
	end

	// burst layout: '&' and the name on a flush, then the trailing character
	assign base_idx = fl ? SLOT_W'(ecnt_q) + SLOT_W'(1) : '0;
	assign req = base_idx + SLOT_W'(trail);
	assign n_emit = (avail < LEN_W'(req)) ? SLOT_W'(avail) : req;
	assign emitted_d = (din == '0) ? '0 : emitted_q + LEN_W'(n_emit);

	always_comb begin
		slot_d[0] = (trail && base_idx == '0) ? tch : hte_pkg::CH_AMP[CHAR_W-1:0];
		for (int k = 1; k < SLOTS; k++) begin
			if (trail && base_idx == SLOT_W'(k))
				slot_d[k] = tch;
			else if (k <= ENTITY_NAME_MAX)
				slot_d[k] = ebuf_q[k-1];
			else
				slot_d[k] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= hte_pkg::LIMIT_RESET;
			mode_q <= hte_pkg::M_TEXT;
			otp_q <= '0;
			ctp_q <= '0;
			ecnt_q <= '0;
			emitted_q <= '0;
			reached_q <= 1'b0;
		end else begin
			if (cfg_we)
				limit_q <= cfg_wdata;
			if (accept) begin
				mode_q <= mode_d;
				otp_q <= otp_d;
				ctp_q <= ctp_d;
				ecnt_q <= ecnt_d;
				emitted_q <= emitted_d;
				reached_q <= reached_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr_en)
			ebuf_q[ecnt_q[IDX_W-1:0]] <= din[CHAR_W-1:0];
	end

	// burst control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			end_q <= 1'b0;
		end else if (accept) begin
			left_q <= n_emit;
			end_q <= (din == '0);
		end else if (pop) begin
			if (left_q != '0)
				left_q <= left_q - SLOT_W'(1);
			else
				end_q <= 1'b0;
		end
	end

	// burst payload
	always_ff @(posedge clk) begin
		if (accept) begin
			base_q <= emitted_q;
			for (int k = 0; k < SLOTS; k++)
				slot_q[k] <= slot_d[k];
		end else if (pop && left_q != '0) begin
			base_q <= base_q + LEN_W'(1);
			for (int k = 0; k < SLOTS - 1; k++)
				slot_q[k] <= slot_q[k+1];
		end
	end

	assign one_left = (left_q == SLOT_W'(1) && !end_q) || (left_q == '0 && end_q);
	assign text_out.valid = (left_q != '0) || end_q;
	assign doc_in.ready = !text_out.valid || (one_left && text_out.ready);

	assign text_out.char_valid = (left_q != '0);
	assign text_out.end_of_text = (left_q == '0) && end_q;
	assign text_out.text_byte = (left_q != '0) ? slot_q[0] : '0;
	assign text_out.text_length = (left_q != '0) ? base_q + LEN_W'(1) : base_q;

	`HTE_ASSERT_NXT(a_doc_end_clears, accept && (din == '0), (mode_q == hte_pkg::M_TEXT) && (emitted_q == '0) && !reached_q)
	`HTE_ASSERT_IMP(a_burst_tracks_count, (left_q != '0) && !end_q, emitted_q == base_q + LEN_W'(left_q))
	`HTE_ASSERT_NXT(a_limit_sticky, reached_q && !(accept && (din == '0)), reached_q)

endmodule
